// ===== hdl/dfs_preorder_adjacency_walk_top_defines.svh =====
// Assertion macros for the depth-first walk block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DFS_PREORDER_ADJACENCY_WALK_TOP_DEFINES_SVH
`define DFS_PREORDER_ADJACENCY_WALK_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dfs_pkg.sv =====
package dfs_pkg;

    localparam int VTX_W = 3;
    localparam int ROW_W = 8;
    localparam int ADJ_W = 64;

    typedef logic [VTX_W-1:0] vertex_t;
    typedef logic [ADJ_W-1:0] adj_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic push;
        logic pop;
        logic load_out;
        logic out_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic found;
        logic depth_one;
    } status_t;

endpackage

// ===== hdl/dfs_if.sv =====
interface dfs_in_if;
    logic             valid;
    logic             ready;
    dfs_pkg::vertex_t start_vertex;

    modport source (output valid, output start_vertex, input ready);
    modport sink   (input valid, input start_vertex, output ready);
endinterface

interface dfs_out_if;
    logic             valid;
    logic             ready;
    dfs_pkg::vertex_t visited_vertex;
    logic             last_of_walk;

    modport source (output valid, output visited_vertex, output last_of_walk, input ready);
    modport sink   (input valid, input visited_vertex, input last_of_walk, output ready);
endinterface

// ===== hdl/dfs_preorder_adjacency_walk_top.sv =====
// The start vertex is held as the pending word once accepted and is presented only when
// a scan step shows whether it is the last word of the walk. A new start is accepted
// in the cycle after the walk ends.
// The walk takes one push or pop per cycle; a push waits while the output word is not taken.
// Reset (rst_n, async, active low): idle, output empty, adjacency cleared to zero;
// stack contents are not cleared.
`include "dfs_preorder_adjacency_walk_top_defines.svh"

module dfs_preorder_adjacency_walk_top #(
    parameter int VERTEX_COUNT = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  dfs_pkg::adj_t cfg_wr_data,
    dfs_in_if.sink        in_ch,
    dfs_out_if.source     out_ch
);

    dfs_pkg::cmd_t    cmd;
    dfs_pkg::status_t status;

    // Controller: steps the walk one push or pop per cycle (a push waits for a
    // free output word) and owns the output valid; the held vertex is released
    // only once the next step shows whether it was the last word of the walk.
    dfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: adjacency register, visited mask, vertex stack, priority
    // scan of the top vertex's row, and the output payload register.
    dfs_dp #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .start_vertex   (in_ch.start_vertex),
        .cmd            (cmd),
        .status         (status),
        .visited_vertex (out_ch.visited_vertex),
        .last_of_walk   (out_ch.last_of_walk)
    );

    // Never overwrite a word the sink has not taken.
    `DFS_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_ch.valid || out_ch.ready, "output word overwritten")
    // A walk in progress blocks new starts.
    `DFS_ASSERT_NEXT(a_busy_after_start, in_ch.valid && in_ch.ready, !in_ch.ready, "input ready during walk")
    // Finishing a walk always produces a word.
    `DFS_ASSERT_NEXT(a_last_presented, cmd.load_out && cmd.out_last, out_ch.valid && out_ch.last_of_walk, "last word not presented")

endmodule

// ===== hdl/dfs_dp.sv =====
module dfs_dp #(
    parameter int VERTEX_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  dfs_pkg::adj_t      cfg_wr_data,
    input  dfs_pkg::vertex_t   start_vertex,
    input  dfs_pkg::cmd_t      cmd,
    output dfs_pkg::status_t   status,
    output dfs_pkg::vertex_t   visited_vertex,
    output logic               last_of_walk
);

    localparam int IDX_W   = $clog2(VERTEX_COUNT);
    localparam int DEPTH_W = $clog2(VERTEX_COUNT + 1);

    dfs_pkg::adj_t             adj_reg;
    logic [VERTEX_COUNT-1:0]   visited_reg;
    logic [DEPTH_W-1:0]        depth_reg;
    dfs_pkg::vertex_t          stack_mem [VERTEX_COUNT];
    dfs_pkg::vertex_t          pend_reg;
    dfs_pkg::vertex_t          out_vertex_reg;
    logic                      out_last_reg;

    dfs_pkg::vertex_t          start_sat;
    logic [IDX_W-1:0]          top_idx;
    dfs_pkg::vertex_t          top_vertex;
    logic [dfs_pkg::ROW_W-1:0] row;
    logic [VERTEX_COUNT-1:0]   cand;
    dfs_pkg::vertex_t          next_v;
    logic [VERTEX_COUNT-1:0]   start_mask;
    logic [VERTEX_COUNT-1:0]   next_mask;

    // Saturate out-of-range start vertices.
    assign start_sat = (int'(start_vertex) >= VERTEX_COUNT)
                     ? dfs_pkg::vertex_t'(VERTEX_COUNT - 1) : start_vertex;

    assign top_idx    = IDX_W'(depth_reg - DEPTH_W'(1));
    assign top_vertex = stack_mem[top_idx];
    assign row        = adj_reg[{top_vertex, 3'b000} +: dfs_pkg::ROW_W];
    assign cand       = row[VERTEX_COUNT-1:0] & ~visited_reg;

    // Lowest unvisited neighbor of the top vertex.
    always_comb
    begin
        next_v = '0;
        for (int i = VERTEX_COUNT - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                next_v = dfs_pkg::vertex_t'(i);
            end
        end
    end

    assign start_mask = VERTEX_COUNT'(1) << start_sat;
    assign next_mask  = VERTEX_COUNT'(1) << next_v;

    assign status.found     = |cand;
    assign status.depth_one = (depth_reg == DEPTH_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_reg     <= '0;
            visited_reg <= '0;
            depth_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                adj_reg <= cfg_wr_data;
            end
            if (cmd.start)
            begin
                visited_reg <= start_mask;
                depth_reg   <= DEPTH_W'(1);
            end
            else if (cmd.push)
            begin
                visited_reg <= visited_reg | next_mask;
                depth_reg   <= depth_reg + DEPTH_W'(1);
            end
            else if (cmd.pop)
            begin
                depth_reg <= depth_reg - DEPTH_W'(1);
            end
        end
    end

    // Stack and payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            stack_mem[0] <= start_sat;
            pend_reg     <= start_sat;
        end
        else if (cmd.push)
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= next_v;
            pend_reg                        <= next_v;
        end
        if (cmd.load_out)
        begin
            out_vertex_reg <= pend_reg;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign visited_vertex = out_vertex_reg;
    assign last_of_walk   = out_last_reg;

endmodule

// ===== hdl/dfs_ctrl.sv =====
module dfs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  dfs_pkg::status_t status,
    output dfs_pkg::cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.found)
                begin
                    // Release the held vertex and descend.
                    if (out_free)
                    begin
                        cmd.push       = 1'b1;
                        cmd.load_out   = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
                else if (!status.depth_one)
                begin
                    cmd.pop = 1'b1;
                end
                else if (out_free)
                begin
                    // Walk done: release the held vertex as the last word.
                    cmd.pop        = 1'b1;
                    cmd.load_out   = 1'b1;
                    cmd.out_last   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Vertex count the block is built with; the parameter is left at its default.
    localparam int NUM_VERTICES = 8;
    // Cycles to let pass after the last word of a phase before touching the register:
    // a full walk of pushes and pops plus margin.
    localparam int SETTLE_CYCLES = 2 * NUM_VERTICES + 8;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 76;

    // One output word as the walk should present it.
    typedef struct packed {
        dfs_pkg::vertex_t vertex;
        logic             last;
    } walk_word_t;

    // Scoreboard: keeps its own copy of the adjacency register, replays each
    // accepted start vertex as a depth-first preorder walk and queues the words
    // that walk must produce, then matches returned words against them in order.
    class walk_scoreboard;
        dfs_pkg::adj_t adjacency;
        walk_word_t    expected_words[$];
        int            errors;

        function new();
            adjacency = '0;
            errors = 0;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        function int pending();
            return expected_words.size();
        endfunction

        // Preorder walk with an explicit stack of (vertex, next column) pairs.
        function void note_start(dfs_pkg::vertex_t start_in);
            logic [NUM_VERTICES-1:0] seen;
            dfs_pkg::vertex_t        stack_vertex [NUM_VERTICES];
            int unsigned             stack_col [NUM_VERTICES];
            walk_word_t              walk[$];
            walk_word_t              word;
            int unsigned             depth;
            int unsigned             top;
            int unsigned             col;
            int unsigned             nbr;
            dfs_pkg::vertex_t        here;
            dfs_pkg::vertex_t        origin;
            bit                      found;

            origin = (int'(start_in) >= NUM_VERTICES)
                   ? dfs_pkg::vertex_t'(NUM_VERTICES - 1) : start_in;
            seen = '0;
            seen[origin] = 1'b1;
            word.vertex = origin;
            word.last = 1'b0;
            walk.push_back(word);
            stack_vertex[0] = origin;
            stack_col[0] = 0;
            depth = 1;

            while (depth > 0) begin
                top = depth - 1;
                here = stack_vertex[top];
                col = stack_col[top];
                found = 0;
                while (col < NUM_VERTICES && !found) begin
                    nbr = col;
                    col++;
                    if (adjacency[here * 8 + nbr] && !seen[nbr]) begin
                        stack_col[top] = col;
                        seen[nbr] = 1'b1;
                        word.vertex = dfs_pkg::vertex_t'(nbr);
                        walk.push_back(word);
                        if (depth < NUM_VERTICES) begin
                            stack_vertex[depth] = dfs_pkg::vertex_t'(nbr);
                            stack_col[depth] = 0;
                            depth++;
                        end
                        found = 1;
                    end
                end
                if (!found)
                    depth--;
            end

            walk[walk.size() - 1].last = 1'b1;
            foreach (walk[i])
                expected_words.push_back(walk[i]);
        endfunction

        task check_word(dfs_pkg::vertex_t vertex, logic last);
            walk_word_t want;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word vertex=%0d last=%0b", vertex, last));
                return;
            end
            want = expected_words.pop_front();
            if (vertex !== want.vertex)
                report($sformatf("visited_vertex got %0d want %0d", vertex, want.vertex));
            if (last !== want.last)
                report($sformatf("last_of_walk got %0b want %0b (vertex %0d)",
                                 last, want.last, want.vertex));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          cfg_wr_en;
    dfs_pkg::adj_t cfg_wr_data;

    dfs_in_if  in_ch ();
    dfs_out_if out_ch ();

    dfs_preorder_adjacency_walk_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    walk_scoreboard sb;

    // Idling switch for both sides; cleared for the final stretch of the run.
    bit idle_on;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_request;

    // 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Safety net: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Check every word the receiver takes, sampled on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.visited_vertex, out_ch.last_of_walk);
    end

    // Receiver: toggle ready in random bursts, hold off for a long stretch on request,
    // and stay ready once idling is switched off. Each pass assigns ready once on a
    // falling edge and then holds it for the chosen number of cycles.
    initial
    begin
        int unsigned span;
        bit          rdy;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request) begin
                rdy = 1'b0;
                span = HOLD_OFF_CYCLES;
                hold_request = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                rdy = 1'b0;
                span = $urandom_range(1, 10);
            end else begin
                rdy = 1'b1;
                span = idle_on ? $urandom_range(1, 20) : 1;
            end
            @(negedge clk);
            out_ch.ready <= rdy;
            repeat (span - 1) @(negedge clk);
        end
    end

    // Offer one start vertex and hold it until the block takes it; note the word
    // on the accepting edge so the expectations exist before any result returns.
    task automatic send_start(dfs_pkg::vertex_t start_vertex);
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.start_vertex <= start_vertex;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_start(start_vertex);
    endtask

    // Drop valid for a random burst, only while idling is enabled.
    task automatic maybe_pause_sender();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Stop offering, wait for every expected word, then let the walk engine settle.
    task automatic drain_walks();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load the adjacency register for one cycle; only called with the block idle.
    task automatic load_adjacency(dfs_pkg::adj_t bits);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= bits;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.adjacency = bits;
    endtask

    // Pick a random graph; the density varies from sparse to nearly complete.
    function automatic dfs_pkg::adj_t random_graph();
        dfs_pkg::adj_t a;
        dfs_pkg::adj_t b;
        dfs_pkg::adj_t c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return a & b & c;
            1: return a & b;
            2: return a;
            3: return a | b;
            default: return a | b | c;
        endcase
    endfunction

    initial
    begin
        dfs_pkg::adj_t graph;

        sb = new();
        idle_on = 1;
        hold_request = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.start_vertex = '0;

        // Hold reset, then release it on a falling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // Empty graph: every walk is just its start vertex, flagged last.
        load_adjacency('0);
        send_start(3'd0);
        send_start(3'd7);
        send_start(3'd5);
        drain_walks();

        // Complete graph with self loops: every walk reaches all vertices,
        // the start first, then the rest in index order.
        load_adjacency('1);
        send_start(3'd0);
        send_start(3'd7);
        send_start(3'd3);
        drain_walks();

        // Chain 0->1->..->7 with self loops and edges back to 0: the walk from 0
        // fills the stack to full depth; back edges and loops must be skipped.
        graph = '0;
        for (int v = 0; v < NUM_VERTICES; v++) begin
            graph[v * 8 + v] = 1'b1;
            graph[v * 8] = 1'b1;
            if (v + 1 < NUM_VERTICES)
                graph[v * 8 + v + 1] = 1'b1;
        end
        load_adjacency(graph);
        send_start(3'd0);
        send_start(3'd4);
        send_start(3'd7);
        drain_walks();

        // Branching graph that forces backtracking across several levels:
        // 0->{2,5}, 2->{0,6}, 5->1, 1->2, 6->3, 7->4, 3 and 4 have no successors.
        graph = '0;
        graph[0 * 8 + 5] = 1'b1;
        graph[0 * 8 + 2] = 1'b1;
        graph[2 * 8 + 6] = 1'b1;
        graph[2 * 8 + 0] = 1'b1;
        graph[5 * 8 + 1] = 1'b1;
        graph[1 * 8 + 2] = 1'b1;
        graph[6 * 8 + 3] = 1'b1;
        graph[7 * 8 + 4] = 1'b1;
        load_adjacency(graph);
        send_start(3'd0);
        send_start(3'd7);
        send_start(3'd4);
        send_start(3'd6);
        send_start(3'd5);
        drain_walks();

        // Random graphs, random start vertices. The second phase opens with a long
        // receiver hold-off while the sender keeps offering back to back, so the
        // block backs up and stalls its input. The last phase runs with no idling.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1)
                idle_on = 0;
            load_adjacency(random_graph());
            if (phase == 1)
                hold_request = 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (!(phase == 1 && n < 30))
                    maybe_pause_sender();
                send_start(dfs_pkg::vertex_t'($urandom_range(0, NUM_VERTICES - 1)));
            end
            drain_walks();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
